/* rtl/hsm_pkg.sv */
// shared constants and types of the half-sample mode estimator
`default_nettype none

package hsm_pkg;

   // default configuration
   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // flags that travel with each queued sample
   typedef struct packed {
      logic usable;
      logic last;
   } hsm_flags_type;

endpackage : hsm_pkg

`default_nettype wire

/* rtl/hsm_ram.sv */
// generic single-write, single-read memory with registered read data
`default_nettype none

module hsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : hsm_ram

`default_nettype wire

/* rtl/hsm_front.sv */
// front end: accepts transactions, drops ones with no effect, queues the rest
`default_nettype none

module hsm_front import hsm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_usable,
   input  wire logic                   req_last,
   output logic                        q_valid,
   input  wire logic                   q_pop,
   output logic      [SAMPLE_BITS-1:0] q_sample,
   output hsm_flags_type               q_flags
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [SAMPLE_BITS-1:0] sample_ff [QUEUE_DEPTH];
   hsm_flags_type          flags_ff  [QUEUE_DEPTH];
   logic [PW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PW:0]            fill_ff, fill_in;
   logic                   accept;
   logic                   keep;
   logic                   push;
   logic                   pop;

   // accept when there is room; items neither usable nor last change nothing
   assign req_stall = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign keep      = req_usable || req_last;
   assign push      = accept && keep;
   assign pop       = q_pop && q_valid;

   assign q_valid  = (fill_ff != '0);
   assign q_sample = sample_ff[rd_ptr_ff];
   assign q_flags  = flags_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         sample_ff[wr_ptr_ff]     <= req_sample;
         flags_ff[wr_ptr_ff]      <= '{usable: req_usable, last: req_last};
      end
   end

endmodule : hsm_front

`default_nettype wire

/* rtl/hsm_back.sv */
// back end: stores samples, sorts them and runs the half-sample mode search
`default_nettype none

module hsm_back import hsm_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire logic [SAMPLE_BITS-1:0] q_sample,
   input  wire hsm_flags_type          q_flags,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [SAMPLE_BITS-1:0] rsp_mode_value,
   output logic                        rsp_status
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SB = SAMPLE_BITS;

   typedef enum logic [3:0] {
      S_LOAD, S_SORT_RD, S_SORT_V, S_SORT_CMP, S_SORT_PUT,
      S_H_CHECK, S_H_RD, S_H_EV, S_F_RD, S_F_EV1, S_F_EV2, S_EMIT
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   n_ff;
   logic [CW-1:0]   i_ff;
   logic [CW-1:0]   h_ff;
   logic [CW-1:0]   best_ff;
   logic [AW-1:0]   k_ff;
   logic [AW-1:0]   base_ff;
   logic [SB-1:0]   v_ff;
   logic [SB-1:0]   bw_ff;
   logic [SB-1:0]   x0_ff;
   logic [SB-1:0]   x1_ff;
   logic [SB-1:0]   res_value_ff;
   logic            res_status_ff;
   logic            rsp_valid_ff;
   logic [SB-1:0]   rsp_mode_value_ff;
   logic            rsp_status_ff;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [SB-1:0]   wr_data;
   logic [AW-1:0]   addr_a;
   logic [AW-1:0]   addr_b;
   logic [SB-1:0]   qa;
   logic [SB-1:0]   qb;
   logic            store_ok;
   logic [CW-1:0]   cnt_next;
   logic [CW:0]     h_wide;
   logic [CW-1:0]   win_start;
   logic [SB-1:0]   win_span;
   logic [SB-1:0]   lo_gap;
   logic [SB-1:0]   hi_gap;
   logic [SB-1:0]   mean01;
   logic [SB-1:0]   mean12;
   logic [SB:0]     sum01;
   logic [SB:0]     sum12;

   // two mirrored copies give two read ports
   hsm_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_a),
      .rd_data (qa)
   );

   hsm_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_b),
      .rd_data (qb)
   );

   // load-phase helpers
   assign q_pop    = (state_ff == S_LOAD) && q_valid;
   assign store_ok = q_flags.usable && (cnt_ff != CW'(MAX_SAMPLES));
   assign cnt_next = store_ok ? cnt_ff + 1'b1 : cnt_ff;

   // window search helpers
   assign h_wide    = ({1'b0, n_ff} + 1'b1) >> 1;
   assign win_start = CW'(base_ff) + i_ff;
   assign win_span  = qb - qa;

   // final pick among up to three values
   assign sum01  = {1'b0, x0_ff} + {1'b0, x1_ff};
   assign sum12  = {1'b0, x1_ff} + {1'b0, qa};
   assign mean01 = sum01[SB:1];
   assign mean12 = sum12[SB:1];
   assign lo_gap = x1_ff - x0_ff;
   assign hi_gap = qa - x1_ff;

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = v_ff;
      case (state_ff)
         S_LOAD: begin
            wr_en   = q_valid && store_ok;
            wr_addr = cnt_ff[AW-1:0];
            wr_data = q_sample;
         end
         S_SORT_CMP: begin
            wr_en   = (qb > v_ff);
            wr_data = qb;
         end
         S_SORT_PUT: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // memory read addresses
   always_comb begin
      addr_a = i_ff[AW-1:0];
      addr_b = k_ff - 1'b1;
      case (state_ff)
         S_SORT_RD:  addr_a = i_ff[AW-1:0];
         S_SORT_V:   addr_b = i_ff[AW-1:0] - 1'b1;
         S_SORT_CMP: addr_b = k_ff - AW'(2);
         S_H_RD: begin
            addr_a = win_start[AW-1:0];
            addr_b = AW'(win_start + h_ff - 1'b1);
         end
         S_F_RD: begin
            addr_a = base_ff;
            addr_b = base_ff + 1'b1;
         end
         S_F_EV1:    addr_a = base_ff + AW'(2);
         default:    addr_a = i_ff[AW-1:0];
      endcase
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (q_valid) begin
                  if (q_flags.last) begin
                     n_ff    <= cnt_next;
                     cnt_ff  <= '0;
                     base_ff <= '0;
                     i_ff    <= CW'(1);
                     state_ff <= (cnt_next > CW'(1)) ? S_SORT_RD : S_H_CHECK;
                  end else begin
                     cnt_ff <= cnt_next;
                  end
               end
            end
            S_SORT_RD: begin
               state_ff <= S_SORT_V;
            end
            S_SORT_V: begin
               v_ff     <= qa;
               k_ff     <= i_ff[AW-1:0];
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if (qb > v_ff) begin
                  k_ff <= k_ff - 1'b1;
                  if (k_ff == AW'(1)) begin
                     state_ff <= S_SORT_PUT;
                  end
               end else begin
                  state_ff <= S_SORT_PUT;
               end
            end
            S_SORT_PUT: begin
               if (i_ff == n_ff - 1'b1) begin
                  state_ff <= S_H_CHECK;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SORT_RD;
               end
            end
            S_H_CHECK: begin
               i_ff <= '0;
               if (n_ff == '0) begin
                  res_value_ff  <= '0;
                  res_status_ff <= STATUS_EMPTY;
                  state_ff      <= S_EMIT;
               end else if (n_ff > CW'(3)) begin
                  h_ff     <= h_wide[CW-1:0];
                  state_ff <= S_H_RD;
               end else begin
                  state_ff <= S_F_RD;
               end
            end
            S_H_RD: begin
               state_ff <= S_H_EV;
            end
            S_H_EV: begin
               if (i_ff == '0 || win_span < bw_ff) begin
                  bw_ff   <= win_span;
                  best_ff <= i_ff;
               end
               if (i_ff == n_ff - h_ff) begin
                  if (i_ff != '0 && win_span < bw_ff) begin
                     base_ff <= AW'(win_start);
                  end else begin
                     base_ff <= AW'(CW'(base_ff) + best_ff);
                  end
                  n_ff     <= h_ff;
                  state_ff <= S_H_CHECK;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_H_RD;
               end
            end
            S_F_RD: begin
               state_ff <= S_F_EV1;
            end
            S_F_EV1: begin
               x0_ff    <= qa;
               x1_ff    <= qb;
               state_ff <= S_F_EV2;
            end
            S_F_EV2: begin
               res_status_ff <= STATUS_OK;
               if (n_ff == CW'(1)) begin
                  res_value_ff <= x0_ff;
               end else if (n_ff == CW'(2)) begin
                  res_value_ff <= mean01;
               end else if (lo_gap < hi_gap) begin
                  res_value_ff <= mean01;
               end else if (lo_gap > hi_gap) begin
                  res_value_ff <= mean12;
               end else begin
                  res_value_ff <= x1_ff;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_mode_value_ff <= res_value_ff;
                  rsp_status_ff     <= res_status_ff;
                  state_ff          <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_value = rsp_mode_value_ff;
   assign rsp_status     = rsp_status_ff;

   // insertion never shifts past the first entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SORT_CMP |-> k_ff != '0)
      else $error("sort index reached zero in compare");

   // fill count never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES))
      else $error("sample count overflow");

   // window scan stays inside the current run
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_H_EV |-> (i_ff <= n_ff - h_ff) && (h_ff < n_ff))
      else $error("window scan out of range");

   // a result is only raised from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit");

endmodule : hsm_back

`default_nettype wire

/* rtl/half_sample_mode_estimator_top.sv */
// Sequence: each usable queued sample is stored as it is popped; on the last transaction the store
// is insertion-sorted in place, then each halving scan tests every window start of the current
// run, and a final pick chooses among up to three values.
// Sample sets are handled one at a time, paced by the sort loop on the store's single write port.
// Reset: synchronous, active high; clears queue pointers, count, sequencer and output valid.
// The sample store is not cleared; only written entries are ever read.
`default_nettype none

module half_sample_mode_estimator_top import hsm_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_usable,
   input  wire logic                   req_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [SAMPLE_BITS-1:0] rsp_mode_value,
   output logic                        rsp_status
);

   logic                   q_valid;
   logic                   q_pop;
   logic [SAMPLE_BITS-1:0] q_sample;
   hsm_flags_type          q_flags;

   // front end with transaction queue
   hsm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_usable (req_usable),
      .req_last   (req_last),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_sample   (q_sample),
      .q_flags    (q_flags)
   );

   // storage, sort and mode search
   hsm_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_sample       (q_sample),
      .q_flags        (q_flags),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mode_value (rsp_mode_value),
      .rsp_status     (rsp_status)
   );

endmodule : half_sample_mode_estimator_top

`default_nettype wire
